FILE: rtl/fsgb_pkg.sv
// Package for the free-space gap builder.
// Holds command and status codes, table entry layouts and sequencer states.
// No dependencies.
package fsgb_pkg;

    // Input command codes
    typedef enum logic [2:0] {
        CMD_DEFINE  = 3'd0,
        CMD_RECORD  = 3'd1,
        CMD_EXTENT  = 3'd2,
        CMD_FINISH  = 3'd3,
        CMD_RESTART = 3'd4
    } cmd_t;

    // Status codes of a status result
    typedef enum logic [3:0] {
        ST_OK             = 4'd0,
        ST_NO_CHUNK       = 4'd1,
        ST_DUP            = 4'd2,
        ST_NO_GROUP       = 4'd3,
        ST_BEHIND         = 4'd4,
        ST_OVERFLOW       = 4'd5,
        ST_MISSING        = 4'd6,
        ST_USED_MISMATCH  = 4'd7,
        ST_FREE_MISMATCH  = 4'd8,
        ST_TOTAL_MISMATCH = 4'd9,
        ST_ABORTED        = 4'd10
    } status_t;

    // Configuration register indexes
    localparam logic [1:0] REG_GROUP_COUNT    = 2'd0;
    localparam logic [1:0] REG_EXPECTED_TOTAL = 2'd1;

    // Result kinds
    localparam logic KIND_FREE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Chunk table entry
    typedef struct packed {
        logic [63:0] base;
        logic [63:0] size;
    } chunk_entry_t;

    // Group table entry
    typedef struct packed {
        logic [63:0] base;
        logic [63:0] size;
        logic [63:0] disk_used;
        logic [63:0] cursor;
        logic [63:0] build_used;
        logic [63:0] free_total;
    } grp_entry_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CH_SCAN,
        S_GR_CHECK,
        S_G_SCAN,
        S_G_GAP,
        S_G_GAP2,
        S_G_USED,
        S_F_CHK,
        S_F_TAIL,
        S_F_TAIL2,
        S_F_FREE,
        S_F_TOTAL,
        S_FREE_EMIT,
        S_EMIT
    } state_t;

endpackage

FILE: rtl/fsgb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the chunk and group tables. No dependencies.
module fsgb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/free_space_gap_builder.sv
// Free-space gap builder, top level.
// Depends on fsgb_pkg and fsgb_ram (chunk table and group table).
//
// Channel  | Dir | Signals                          | Payload
// s_       | in  | s_tvalid s_tready s_tdata s_tuser | command, slot, address, length, used
// m_       | out | m_tvalid m_tready m_tdata m_tuser m_tlast | kind, group, free extent, status
// cfg_     | in  | cfg_valid cfg_ready cfg_index cfg_data | register writes, always ready
//
// One item at a time; the record and extent scans walk the tables one slot a
// cycle through the registered read port, and the finish pass checks each group
// slot in use in turn. Each result stalls while the output register is full.
// Reset is synchronous, active low; no clearing pass.
module free_space_gap_builder #(
    parameter int MAX_GROUPS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    // slave: slot [3:0], address [67:4], length [131:68], used_bytes [195:132]
    input  logic [199:0]  s_tdata,
    // slave: command [2:0]
    input  logic [2:0]    s_tuser,
    input  logic          s_tvalid,
    output logic          s_tready,
    // master: group_index [3:0], free_start [67:4], free_length [131:68], status [135:132]
    output logic [135:0]  m_tdata,
    // master: kind [0]
    output logic          m_tuser,
    output logic          m_tlast,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [63:0]   cfg_data
);
    import fsgb_pkg::*;

    localparam int IW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int NW = $clog2(MAX_GROUPS + 1);

    state_t state_reg, state_next, resume_reg, resume_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [63:0] addr_reg, addr_next, len_reg, len_next, used_reg, used_next;
    logic [63:0] end_reg, end_next, delta_reg, delta_next;
    logic [63:0] total_reg, total_next, exp_reg;
    logic [4:0]  gcount_reg;
    logic        failed_reg, failed_next;
    status_t     code_reg, code_next;
    grp_entry_t  ent_reg, ent_next;
    logic [MAX_GROUPS-1:0] gvalid_reg, gvalid_next;

    logic          m_valid_reg, m_valid_next, m_kind_reg, m_kind_next, m_last_reg, m_last_next;
    logic [3:0]    m_gidx_reg, m_gidx_next;
    status_t       m_status_reg, m_status_next;
    logic [63:0]   m_start_reg, m_start_next, m_len_reg, m_len_next;

    // Table ports
    logic          cw_en, gw_en;
    chunk_entry_t  cw_data, c_rdata;
    grp_entry_t    gw_data, g_rdata, g_eff;
    logic [IW-1:0] cw_addr;

    // Input fields
    cmd_t        in_cmd;
    logic [3:0]  in_slot;
    logic [63:0] in_addr, in_len, in_used;
    logic [64:0] in_end;

    assign in_cmd  = cmd_t'(s_tuser);
    assign in_slot = s_tdata[3:0];
    assign in_addr = s_tdata[67:4];
    assign in_len  = s_tdata[131:68];
    assign in_used = s_tdata[195:132];
    assign in_end  = {1'b0, in_addr} + {1'b0, in_len};

    // Slots in use, clipped to the table depth
    logic [6:0]    gc_wide;
    logic [NW-1:0] n_slots;
    logic          idx_last, can_load;
    assign gc_wide  = {2'b00, gcount_reg};
    assign n_slots  = (gc_wide > 7'(MAX_GROUPS)) ? NW'(MAX_GROUPS) : NW'(gc_wide);
    assign idx_last = (NW'(idx_reg) + NW'(1)) == n_slots;
    assign can_load = !m_valid_reg || m_tready;

    // Group entries never written read as zero
    assign g_eff = gvalid_reg[idx_reg] ? g_rdata : '0;

    // Shared decisions
    logic chunk_hit, g_below, g_fit, behind, gap_ovf, used_ovf, tail_ovf, free_bad;
    logic slot_ok;
    assign chunk_hit = (c_rdata.base == addr_reg) && (c_rdata.size == len_reg);
    assign g_below   = addr_reg < g_eff.base;
    assign g_fit     = (end_reg - g_eff.base) <= g_eff.size;
    assign behind    = addr_reg < ent_reg.cursor;
    assign gap_ovf   = ent_reg.free_total > ~delta_reg;
    assign used_ovf  = (ent_reg.build_used > ~len_reg) || (total_reg > ~len_reg);
    assign tail_ovf  = ent_reg.free_total > ~delta_reg;
    assign free_bad  = ent_reg.free_total != (ent_reg.size - ent_reg.disk_used);
    assign slot_ok   = {3'b000, in_slot} < 7'(MAX_GROUPS);

    fsgb_ram #(.WIDTH($bits(chunk_entry_t)), .DEPTH(MAX_GROUPS)) u_chunk_ram (
        .aclk  (aclk),
        .we    (cw_en),
        .waddr (cw_addr),
        .wdata (cw_data),
        .raddr (idx_next),
        .rdata (c_rdata)
    );

    fsgb_ram #(.WIDTH($bits(grp_entry_t)), .DEPTH(MAX_GROUPS)) u_group_ram (
        .aclk  (aclk),
        .we    (gw_en),
        .waddr (idx_reg),
        .wdata (gw_data),
        .raddr (idx_next),
        .rdata (g_rdata)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (in_cmd == CMD_RESTART || failed_reg) begin
                        state_next = S_EMIT;
                    end else begin
                        case (in_cmd)
                            CMD_RECORD: state_next = (n_slots == '0) ? S_EMIT : S_CH_SCAN;
                            CMD_EXTENT: state_next = (in_len == '0 || in_end[64] ||
                                                      n_slots == '0) ? S_EMIT : S_G_SCAN;
                            CMD_FINISH: state_next = (n_slots == '0) ? S_F_TOTAL : S_F_CHK;
                            default:    state_next = S_EMIT;
                        endcase
                    end
                end
            end
            S_CH_SCAN:  state_next = chunk_hit ? S_GR_CHECK : (idx_last ? S_EMIT : S_CH_SCAN);
            S_GR_CHECK: state_next = S_EMIT;
            S_G_SCAN: begin
                if (g_eff.size != '0 && g_below) begin
                    state_next = S_EMIT;
                end else if (g_eff.size != '0 && g_fit) begin
                    state_next = S_G_GAP;
                end else if (idx_last) begin
                    state_next = S_EMIT;
                end
            end
            S_G_GAP:  state_next = behind ? S_EMIT : S_G_GAP2;
            S_G_GAP2: begin
                if (delta_reg == '0) begin
                    state_next = S_G_USED;
                end else begin
                    state_next = gap_ovf ? S_EMIT : S_FREE_EMIT;
                end
            end
            S_G_USED: state_next = S_EMIT;
            S_F_CHK: begin
                if (g_eff.size == '0 || g_eff.build_used != g_eff.disk_used) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = S_F_TAIL;
                end
            end
            S_F_TAIL:  state_next = S_F_TAIL2;
            S_F_TAIL2: begin
                if (delta_reg == '0) begin
                    state_next = S_F_FREE;
                end else begin
                    state_next = tail_ovf ? S_EMIT : S_FREE_EMIT;
                end
            end
            S_F_FREE: begin
                if (free_bad) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = idx_last ? S_F_TOTAL : S_F_CHK;
                end
            end
            S_F_TOTAL:   state_next = S_EMIT;
            S_FREE_EMIT: state_next = can_load ? resume_reg : S_FREE_EMIT;
            S_EMIT:      state_next = can_load ? S_IDLE : S_EMIT;
            default:     state_next = S_IDLE;
        endcase
    end

    // Datapath, table accesses and result register
    always_comb begin
        idx_next      = idx_reg;
        addr_next     = addr_reg;
        len_next      = len_reg;
        used_next     = used_reg;
        end_next      = end_reg;
        delta_next    = delta_reg;
        total_next    = total_reg;
        failed_next   = failed_reg;
        code_next     = code_reg;
        ent_next      = ent_reg;
        resume_next   = resume_reg;
        gvalid_next   = gvalid_reg;
        cw_en         = 1'b0;
        cw_addr       = IW'(in_slot);
        cw_data       = '{base: in_addr, size: in_len};
        gw_en         = 1'b0;
        gw_data       = ent_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_kind_next   = m_kind_reg;
        m_last_next   = m_last_reg;
        m_gidx_next   = m_gidx_reg;
        m_status_next = m_status_reg;
        m_start_next  = m_start_reg;
        m_len_next    = m_len_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    addr_next = in_addr;
                    len_next  = in_len;
                    used_next = in_used;
                    end_next  = in_end[63:0];
                    idx_next  = '0;
                    code_next = ST_OK;
                    if (in_cmd == CMD_RESTART) begin
                        gvalid_next = '0;
                        total_next  = '0;
                        failed_next = 1'b0;
                    end else if (failed_reg) begin
                        code_next = ST_ABORTED;
                    end else begin
                        case (in_cmd)
                            CMD_DEFINE: cw_en = slot_ok;
                            CMD_RECORD: if (n_slots == '0) code_next = ST_NO_CHUNK;
                            CMD_EXTENT: if (in_len == '0 || in_end[64] || n_slots == '0)
                                            code_next = ST_NO_GROUP;
                            default: ;
                        endcase
                    end
                end
            end
            S_CH_SCAN: begin
                if (!chunk_hit) begin
                    if (idx_last) code_next = ST_NO_CHUNK;
                    else          idx_next  = idx_reg + IW'(1);
                end
            end
            S_GR_CHECK: begin
                if (g_eff.size != '0) begin
                    code_next = ST_DUP;
                end else begin
                    gw_en   = 1'b1;
                    gw_data = '{base: addr_reg, size: len_reg, disk_used: used_reg,
                                cursor: addr_reg, build_used: g_eff.build_used,
                                free_total: g_eff.free_total};
                    gvalid_next[idx_reg] = 1'b1;
                end
            end
            S_G_SCAN: begin
                ent_next = g_eff;
                if (g_eff.size != '0 && g_below) begin
                    code_next = ST_NO_GROUP;
                end else if (!(g_eff.size != '0 && g_fit)) begin
                    if (idx_last) code_next = ST_NO_GROUP;
                    else          idx_next  = idx_reg + IW'(1);
                end
            end
            S_G_GAP: begin
                delta_next = addr_reg - ent_reg.cursor;
                if (behind) code_next = ST_BEHIND;
            end
            S_G_GAP2: begin
                resume_next = S_G_USED;
                if (delta_reg != '0) begin
                    if (gap_ovf) code_next = ST_OVERFLOW;
                    else ent_next.free_total = ent_reg.free_total + delta_reg;
                end
            end
            S_G_USED: begin
                gw_en = 1'b1;
                if (used_ovf) begin
                    code_next = ST_OVERFLOW;
                end else begin
                    gw_data.build_used = ent_reg.build_used + len_reg;
                    gw_data.cursor     = end_reg;
                    total_next         = total_reg + len_reg;
                end
            end
            S_F_CHK: begin
                ent_next = g_eff;
                if (g_eff.size == '0) begin
                    code_next = ST_MISSING;
                end else if (g_eff.build_used != g_eff.disk_used) begin
                    code_next = ST_USED_MISMATCH;
                end
            end
            S_F_TAIL: delta_next = ent_reg.base + ent_reg.size - ent_reg.cursor;
            S_F_TAIL2: begin
                resume_next = S_F_FREE;
                if (delta_reg != '0) begin
                    if (tail_ovf) code_next = ST_OVERFLOW;
                    else ent_next.free_total = ent_reg.free_total + delta_reg;
                end
            end
            S_F_FREE: begin
                gw_en = 1'b1;
                if (free_bad) begin
                    code_next = ST_FREE_MISMATCH;
                end else begin
                    gw_data.cursor     = '0;
                    gw_data.build_used = '0;
                    if (!idx_last) idx_next = idx_reg + IW'(1);
                end
            end
            S_F_TOTAL: begin
                if (total_reg != exp_reg) code_next = ST_TOTAL_MISMATCH;
            end
            S_FREE_EMIT: begin
                if (can_load) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_FREE;
                    m_last_next   = 1'b0;
                    m_gidx_next   = 4'(idx_reg);
                    m_start_next  = ent_reg.cursor;
                    m_len_next    = delta_reg;
                    m_status_next = ST_OK;
                end
            end
            S_EMIT: begin
                if (can_load) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = KIND_STATUS;
                    m_last_next   = 1'b1;
                    m_gidx_next   = '0;
                    m_start_next  = '0;
                    m_len_next    = '0;
                    m_status_next = code_reg;
                    if (code_reg != ST_OK) failed_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            total_reg   <= '0;
            failed_reg  <= 1'b0;
            gvalid_reg  <= '0;
            gcount_reg  <= '0;
            exp_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            failed_reg  <= failed_next;
            gvalid_reg  <= gvalid_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_index == REG_GROUP_COUNT)    gcount_reg <= cfg_data[4:0];
            if (cfg_valid && cfg_index == REG_EXPECTED_TOTAL) exp_reg    <= cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        addr_reg     <= addr_next;
        len_reg      <= len_next;
        used_reg     <= used_next;
        end_reg      <= end_next;
        delta_reg    <= delta_next;
        code_reg     <= code_next;
        ent_reg      <= ent_next;
        resume_reg   <= resume_next;
        m_kind_reg   <= m_kind_next;
        m_last_reg   <= m_last_next;
        m_gidx_reg   <= m_gidx_next;
        m_status_reg <= m_status_next;
        m_start_reg  <= m_start_next;
        m_len_reg    <= m_len_next;
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = m_kind_reg;
    assign m_tlast   = m_last_reg;
    assign m_tdata   = {m_status_reg, m_len_reg, m_start_reg, m_gidx_reg};
endmodule

FILE: rtl/fsgb_checker.sv
// Port-level checker for the free-space gap builder, with its bind.
// Depends on free_space_gap_builder ports only.
module fsgb_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [135:0] m_tdata,
    input logic         m_tuser,
    input logic         m_tlast,
    input logic         m_tvalid,
    input logic         m_tready
);
    // A stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Status results close an item, free extents never do
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == m_tlast))
        else $error("last flag does not match result kind");

    // Free extent results carry no status code
    a_free_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[135:132] == 4'd0)
        else $error("status code on a free extent");

    // One item at a time: busy right after an input transfer
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");
endmodule

bind free_space_gap_builder fsgb_checker u_fsgb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
